// File: rtl/lse_pkg.sv
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types and constants for the LSB stego extractor: parse phases,
// result kinds and the transaction structs passed between the stages.
// ----------------------------------------------------------------------------
package lse_pkg;

    // default magic word, ascii "STEG", big-endian
    localparam logic [31:0] MAGIC_RESET = 32'h5354_4547;

    // byte counts of the fixed header fields
    localparam logic [31:0] MAGIC_BYTES = 32'd4;
    localparam logic [31:0] SIZE_BYTES  = 32'd4;
    localparam logic [31:0] NLEN_BYTES  = 32'd2;

    // parse phase
    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_SIZE    = 3'd1,
        PH_NLEN    = 3'd2,
        PH_NAME    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DONE    = 3'd5,
        PH_ERROR   = 3'd6
    } t_phase;

    // result kind
    typedef enum logic [1:0] {
        K_NAME    = 2'd0,
        K_PAYLOAD = 2'd1,
        K_HEADER  = 2'd2,
        K_ERROR   = 2'd3
    } t_kind;

    // one input transaction
    typedef struct packed {
        logic [7:0] sample_byte;
        logic       start_req;
    } t_item;

    // one result transaction
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic        last;
        logic [31:0] payload_size;
        logic [15:0] name_length;
    } t_result;

endpackage

// File: rtl/lse_in_stage.sv
// ----------------------------------------------------------------------------
// lse_in_stage
// Input register: captures one sample transaction and holds it until the
// parser consumes it.
// ----------------------------------------------------------------------------
module lse_in_stage
    import lse_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_consume,
    output logic  o_stall,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    // register is free when empty or being drained this cycle
    assign w_load  = !r_valid || i_consume;
    assign o_stall = !w_load;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/lse_parser.sv
// ----------------------------------------------------------------------------
// lse_parser
// Bit collector and header/body parser. Holds the parse state and the magic
// word register; works out one step per consumed transaction.
// ----------------------------------------------------------------------------
module lse_parser
    import lse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_fire,
    input  t_item       i_item,
    output logic        o_res_valid,
    output t_result     o_res
);

    logic [31:0] r_magic_word;
    t_phase      r_phase,  n_phase;
    logic [2:0]  r_bc,     n_bc;
    logic [7:0]  r_shift,  n_shift;
    logic [31:0] r_fc,     n_fc;
    logic [31:0] r_magic,  n_magic;
    logic [31:0] r_size,   n_size;
    logic [15:0] r_nlen,   n_nlen;

    t_phase      s_phase;
    logic [2:0]  s_bc;
    logic [7:0]  s_shift;
    logic [31:0] s_fc;
    logic [31:0] s_magic;
    logic [31:0] s_size;
    logic [15:0] s_nlen;

    logic        w_active;
    logic [7:0]  w_shifted;
    logic [2:0]  w_bc_inc;
    logic        w_byte_done;
    logic [31:0] w_fc_inc;
    logic [31:0] w_magic_next;
    logic [15:0] w_nlen_next;
    logic        w_name_fin;
    logic        w_pay_fin;
    logic        w_magic_end;
    logic        w_magic_bad;
    logic        w_nlen_end;

    // start request clears the parse state before this bit is taken
    assign s_phase = i_item.start_req ? PH_MAGIC : r_phase;
    assign s_bc    = i_item.start_req ? 3'd0     : r_bc;
    assign s_shift = i_item.start_req ? 8'd0     : r_shift;
    assign s_fc    = i_item.start_req ? 32'd0    : r_fc;
    assign s_magic = i_item.start_req ? 32'd0    : r_magic;
    assign s_size  = i_item.start_req ? 32'd0    : r_size;
    assign s_nlen  = i_item.start_req ? 16'd0    : r_nlen;

    // bit collection, msb first
    assign w_active    = (s_phase != PH_DONE) && (s_phase != PH_ERROR);
    assign w_shifted   = {s_shift[6:0], i_item.sample_byte[0]};
    assign w_bc_inc    = s_bc + 3'd1;
    assign w_byte_done = w_active && (w_bc_inc == 3'd0);

    // field counting and compares
    assign w_fc_inc     = s_fc + 32'd1;
    assign w_magic_next = {s_magic[23:0], w_shifted};
    assign w_nlen_next  = {s_nlen[7:0], w_shifted};
    assign w_name_fin   = (w_fc_inc == {16'd0, s_nlen});
    assign w_pay_fin    = (w_fc_inc == s_size);
    assign w_magic_end  = (w_fc_inc == MAGIC_BYTES);
    assign w_magic_bad  = (w_magic_next != r_magic_word);
    assign w_nlen_end   = (w_fc_inc == NLEN_BYTES);

    // next state
    always_comb begin
        n_phase = r_phase;
        n_bc    = r_bc;
        n_shift = r_shift;
        n_fc    = r_fc;
        n_magic = r_magic;
        n_size  = r_size;
        n_nlen  = r_nlen;
        if (i_fire) begin
            n_phase = s_phase;
            n_bc    = s_bc;
            n_shift = s_shift;
            n_fc    = s_fc;
            n_magic = s_magic;
            n_size  = s_size;
            n_nlen  = s_nlen;
            if (w_active) begin
                n_shift = w_shifted;
                n_bc    = w_bc_inc;
            end
            if (w_byte_done) begin
                n_shift = 8'd0;
                case (s_phase)
                    PH_MAGIC: begin
                        n_magic = w_magic_next;
                        n_fc    = w_fc_inc;
                        if (w_magic_end) begin
                            n_fc    = 32'd0;
                            n_phase = w_magic_bad ? PH_ERROR : PH_SIZE;
                        end
                    end
                    PH_SIZE: begin
                        n_size = {s_size[23:0], w_shifted};
                        n_fc   = w_fc_inc;
                        if (w_fc_inc == SIZE_BYTES) begin
                            n_fc    = 32'd0;
                            n_phase = PH_NLEN;
                        end
                    end
                    PH_NLEN: begin
                        n_nlen = w_nlen_next;
                        n_fc   = w_fc_inc;
                        if (w_nlen_end) begin
                            n_fc = 32'd0;
                            if (w_nlen_next != 16'd0) begin
                                n_phase = PH_NAME;
                            end else if (s_size != 32'd0) begin
                                n_phase = PH_PAYLOAD;
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end
                    end
                    PH_NAME: begin
                        n_fc = w_fc_inc;
                        if (w_name_fin) begin
                            n_fc    = 32'd0;
                            n_phase = (s_size != 32'd0) ? PH_PAYLOAD : PH_DONE;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_fc = w_fc_inc;
                        if (w_pay_fin) begin
                            n_fc    = 32'd0;
                            n_phase = PH_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // result outputs
    always_comb begin
        o_res_valid        = 1'b0;
        o_res.kind         = K_NAME;
        o_res.data_byte    = 8'd0;
        o_res.last         = 1'b0;
        o_res.payload_size = n_size;
        o_res.name_length  = n_nlen;
        if (i_fire && w_byte_done) begin
            case (s_phase)
                PH_MAGIC: begin
                    if (w_magic_end && w_magic_bad) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = K_ERROR;
                    end
                end
                PH_NLEN: begin
                    if (w_nlen_end) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = K_HEADER;
                    end
                end
                PH_NAME: begin
                    o_res_valid     = 1'b1;
                    o_res.kind      = K_NAME;
                    o_res.data_byte = w_shifted;
                    o_res.last      = w_name_fin;
                end
                PH_PAYLOAD: begin
                    o_res_valid     = 1'b1;
                    o_res.kind      = K_PAYLOAD;
                    o_res.data_byte = w_shifted;
                    o_res.last      = w_pay_fin;
                end
                default: begin
                end
            endcase
        end
    end

    // magic word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_word <= MAGIC_RESET;
        end else if (i_cfg_we) begin
            r_magic_word <= i_cfg_data;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_bc    <= 3'd0;
            r_shift <= 8'd0;
            r_fc    <= 32'd0;
            r_magic <= 32'd0;
            r_size  <= 32'd0;
            r_nlen  <= 16'd0;
        end else begin
            r_phase <= n_phase;
            r_bc    <= n_bc;
            r_shift <= n_shift;
            r_fc    <= n_fc;
            r_magic <= n_magic;
            r_size  <= n_size;
            r_nlen  <= n_nlen;
        end
    end

    // checks
    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_item.start_req && (r_phase == PH_DONE || r_phase == PH_ERROR))
        |-> !o_res_valid)
        else $error("result produced after parse end");

    a_res_on_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> w_byte_done)
        else $error("result without a completed byte");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == K_ERROR)
        |-> (o_res.payload_size == 32'd0 && o_res.name_length == 16'd0))
        else $error("error result carries non-zero sizes");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> ($stable(r_phase) && $stable(r_fc) && $stable(r_bc)))
        else $error("parse state moved without a transaction");

endmodule

// File: rtl/lse_out_stage.sv
// ----------------------------------------------------------------------------
// lse_out_stage
// Result register: holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module lse_out_stage
    import lse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;
    logic    w_free;

    // register can take a new result when empty or being read out
    assign w_free = !r_valid || !i_stall;
    assign o_free = w_free;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_free) begin
            r_valid <= i_res_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_free && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: rtl/lsb_stego_extractor.sv
// ----------------------------------------------------------------------------
// lsb_stego_extractor
// Recovers a file hidden in the least significant bits of an image byte
// stream: magic check, size and name length header, then name and payload
// bytes.
//
//   channel  direction  handshake                      payload
//   in       input      i_in_valid / o_in_stall        i_sample_byte, i_start_req
//   out      output     o_out_valid / i_out_stall      o_kind, o_data_byte, o_last,
//                                                      o_payload_size, o_name_length
//   cfg      input      i_cfg_valid / o_cfg_ready      i_cfg_data (magic word)
//
// One transaction per cycle sustained while the output does not stall; a result
// is held in the result register once its input has passed the input register
// and then one parse step. The rate is set by the single parse step, a
// 32-bit field count increment and compare. Synchronous reset restores the
// default magic word and clears the parse; no clearing pass. An output stall
// backs up through the result and input registers, each holding its
// transaction.
// ----------------------------------------------------------------------------
module lsb_stego_extractor
    import lse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_sample_byte,
    input  logic        i_start_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic        o_last,
    output logic [31:0] o_payload_size,
    output logic [15:0] o_name_length,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    t_item   w_in_item;
    t_item   w_item;
    logic    w_item_valid;
    logic    w_out_free;
    logic    w_fire;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out_res;

    // configuration writes always taken
    assign o_cfg_ready = 1'b1;

    assign w_in_item.sample_byte = i_sample_byte;
    assign w_in_item.start_req   = i_start_req;

    // parse step runs when an item is held and the result register is free
    assign w_fire = w_item_valid && w_out_free;

    // input register
    lse_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_item    (w_in_item),
        .i_consume (w_fire),
        .o_stall   (o_in_stall),
        .o_valid   (w_item_valid),
        .o_item    (w_item)
    );

    // parser
    lse_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (w_fire),
        .i_item      (w_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // result register
    lse_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .i_stall     (i_out_stall),
        .o_free      (w_out_free),
        .o_valid     (o_out_valid),
        .o_res       (w_out_res)
    );

    // result fields to ports
    assign o_kind         = w_out_res.kind;
    assign o_data_byte    = w_out_res.data_byte;
    assign o_last         = w_out_res.last;
    assign o_payload_size = w_out_res.payload_size;
    assign o_name_length  = w_out_res.name_length;

endmodule

// File: tb/tb_lsb_stego_extractor.sv
// ----------------------------------------------------------------------------
// tb_lsb_stego_extractor
// Self-checking bench for the LSB stego extractor. Streams of image bytes are
// built from hidden files (magic, size, name length, name, payload), spread
// one bit per sample, and driven with random gaps on both handshakes. A
// behavioural parser in the bench predicts every result, which is compared
// field by field with what the block emits.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lsb_stego_extractor;
    import lse_pkg::*;

    localparam int ITEM_GOAL      = 1750;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 4;

    // fill of the seven unused sample bits
    localparam int UP_ZERO = 0;
    localparam int UP_ONES = 1;
    localparam int UP_RAND = 2;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_sample_byte = 8'h00;
    logic        i_start_req = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic        o_last;
    logic [31:0] o_payload_size;
    logic [15:0] o_name_length;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = 32'h0;

    lsb_stego_extractor i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_byte  (i_sample_byte),
        .i_start_req    (i_start_req),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_last         (o_last),
        .o_payload_size (o_payload_size),
        .o_name_length  (o_name_length),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // parser state mirrored in the bench
    logic [31:0] p_magic;
    logic [2:0]  p_bits;
    logic [7:0]  p_shift;
    t_phase      p_phase;
    logic [31:0] p_count;
    logic [31:0] p_magic_acc;
    logic [31:0] p_size;
    logic [15:0] p_nlen;

    t_result     expected_results[$];
    logic [7:0]  stream_bytes[$];

    // a directed stream; the first result is typed in where it is obvious
    typedef struct {
        bit          cfg_wr;
        logic [31:0] cfg_val;
        logic [31:0] magic;
        logic [31:0] size;
        logic [15:0] nlen;
        int          nbody;
        bit          alt;
        int          nbits;
        int          upper;
        bit          typed;
        t_kind       exp_kind;
        logic [31:0] exp_size;
        logic [15:0] exp_nlen;
    } t_stream_row;

    localparam int N_ROWS = 17;
    t_stream_row dir_rows [N_ROWS] = '{
        // empty name and zero payload straight after reset
        '{0, 0, MAGIC_RESET, 0, 0, 0, 0, 0, UP_ZERO, 1, K_HEADER, 0, 0},
        // same again, trailing bits after the end are ignored
        '{0, 0, MAGIC_RESET, 0, 0, 0, 0, 104, UP_ONES, 0, K_NAME, 0, 0},
        // magic mismatches, later bits ignored
        '{0, 0, 32'h0000_0000, 0, 0, 0, 0, 72, UP_RAND, 1, K_ERROR, 0, 0},
        '{0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 32, UP_RAND, 1, K_ERROR, 0, 0},
        '{0, 0, 32'h5354_4546, 0, 0, 0, 0, 40, UP_RAND, 1, K_ERROR, 0, 0},
        // empty name goes straight to the payload
        '{0, 0, MAGIC_RESET, 3, 0, 3, 1, 0, UP_RAND, 1, K_HEADER, 3, 0},
        // name only with trailing bits, then a name followed by a payload
        '{0, 0, MAGIC_RESET, 0, 2, 2, 0, 112, UP_RAND, 0, K_NAME, 0, 0},
        '{0, 0, MAGIC_RESET, 2, 1, 3, 1, 0, UP_ONES, 0, K_NAME, 0, 0},
        // largest sizes, cut short by the next restart
        '{0, 0, MAGIC_RESET, 32'hFFFF_FFFF, 0, 4, 0, 0, UP_RAND,
          1, K_HEADER, 32'hFFFF_FFFF, 0},
        '{0, 0, MAGIC_RESET, 1, 16'hFFFF, 3, 1, 0, UP_RAND, 1, K_HEADER, 1, 16'hFFFF},
        // restart in the middle of a byte, in payload and in magic
        '{0, 0, MAGIC_RESET, 5, 1, 6, 0, 101, UP_RAND, 0, K_NAME, 0, 0},
        '{0, 0, MAGIC_RESET, 0, 0, 0, 0, 19, UP_RAND, 0, K_NAME, 0, 0},
        // register extremes
        '{1, 32'h0000_0000, 32'h0000_0000, 1, 1, 2, 0, 0, UP_RAND, 1, K_HEADER, 1, 1},
        '{1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2, 0, 2, 1, 0, UP_RAND, 0, K_NAME, 0, 0},
        '{0, 0, MAGIC_RESET, 1, 1, 2, 0, 0, UP_RAND, 1, K_ERROR, 0, 0},
        '{1, MAGIC_RESET, MAGIC_RESET, 4, 3, 7, 0, 0, UP_RAND, 0, K_NAME, 0, 0},
        '{0, 0, MAGIC_RESET, 32'h8000_0000, 16'h8000, 2, 1, 0, UP_RAND,
          1, K_HEADER, 32'h8000_0000, 16'h8000}
    };

    int in_idle_pct  = 7;
    int out_idle_pct = 71;
    bit hold_pending = 1'b0;
    bit typed_pending = 1'b0;
    t_result typed_res;

    int samples_sent = 0;
    int parsed_cnt   = 0;
    int stream_cnt   = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int idle_cycles  = 0;
    int kind_cnt [4] = '{0, 0, 0, 0};

    function automatic void clear_parse();
        p_bits      = '0;
        p_shift     = '0;
        p_phase     = PH_MAGIC;
        p_count     = '0;
        p_magic_acc = '0;
        p_size      = '0;
        p_nlen      = '0;
    endfunction

    // one sample through the parser; returns 1 when it completes a result
    function automatic bit parse_sample(input logic [7:0] smp, input logic st,
                                        output t_result res);
        logic [7:0] b;
        bit         produced;
        res      = '0;
        produced = 1'b0;
        if (st)
            clear_parse();
        if (p_phase >= PH_DONE)
            return 1'b0;
        p_shift = {p_shift[6:0], smp[0]};
        p_bits  = p_bits + 3'd1;
        if (p_bits != 3'd0)
            return 1'b0;
        b       = p_shift;
        p_shift = '0;
        case (p_phase)
            PH_MAGIC: begin
                p_magic_acc = {p_magic_acc[23:0], b};
                p_count     = p_count + 1;
                if (p_count == MAGIC_BYTES) begin
                    p_count = '0;
                    if (p_magic_acc != p_magic) begin
                        p_phase  = PH_ERROR;
                        res.kind = K_ERROR;
                        produced = 1'b1;
                    end else begin
                        p_phase = PH_SIZE;
                    end
                end
            end
            PH_SIZE: begin
                p_size  = {p_size[23:0], b};
                p_count = p_count + 1;
                if (p_count == SIZE_BYTES) begin
                    p_count = '0;
                    p_phase = PH_NLEN;
                end
            end
            PH_NLEN: begin
                p_nlen  = {p_nlen[7:0], b};
                p_count = p_count + 1;
                if (p_count == NLEN_BYTES) begin
                    p_count = '0;
                    if (p_nlen != 0)
                        p_phase = PH_NAME;
                    else if (p_size != 0)
                        p_phase = PH_PAYLOAD;
                    else
                        p_phase = PH_DONE;
                    res.kind = K_HEADER;
                    produced = 1'b1;
                end
            end
            PH_NAME: begin
                p_count       = p_count + 1;
                res.kind      = K_NAME;
                res.data_byte = b;
                res.last      = (p_count == {16'd0, p_nlen});
                produced      = 1'b1;
                if (res.last) begin
                    p_count = '0;
                    p_phase = (p_size != 0) ? PH_PAYLOAD : PH_DONE;
                end
            end
            PH_PAYLOAD: begin
                p_count       = p_count + 1;
                res.kind      = K_PAYLOAD;
                res.data_byte = b;
                res.last      = (p_count == p_size);
                produced      = 1'b1;
                if (res.last) begin
                    p_count = '0;
                    p_phase = PH_DONE;
                end
            end
            default: ;
        endcase
        res.payload_size = p_size;
        res.name_length  = p_nlen;
        return produced;
    endfunction

    // header then body bytes, big-endian fields
    function automatic void build_stream(input logic [31:0] mg, input logic [31:0] sz,
                                         input logic [15:0] nl, input int nbody,
                                         input bit alt);
        logic [7:0] bval;
        stream_bytes.delete();
        for (int k = 3; k >= 0; k--)
            stream_bytes = {stream_bytes, mg[8*k +: 8]};
        for (int k = 3; k >= 0; k--)
            stream_bytes = {stream_bytes, sz[8*k +: 8]};
        for (int k = 1; k >= 0; k--)
            stream_bytes = {stream_bytes, nl[8*k +: 8]};
        for (int k = 0; k < nbody; k++) begin
            if (alt)
                bval = (k % 2) ? 8'h00 : 8'hFF;
            else
                bval = 8'($urandom_range(255));
            stream_bytes = {stream_bytes, bval};
        end
    endfunction

    // one input transaction; its results are predicted as it is offered
    task automatic drive_sample(input logic [7:0] smp, input logic st);
        t_result res;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        if (st || p_phase < PH_DONE)
            parsed_cnt++;
        if (parse_sample(smp, st, res)) begin
            if (typed_pending) begin
                res           = typed_res;
                typed_pending = 1'b0;
            end
            expected_results = {expected_results, res};
        end
        samples_sent++;
        i_in_valid    <= 1'b1;
        i_sample_byte <= smp;
        i_start_req   <= st;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // spread stream bits over samples, random bits past the end of the stream
    task automatic send_stream(input int nbits, input int upper, input bit first_start);
        logic [7:0] smp;
        for (int i = 0; i < nbits; i++) begin
            case (upper)
                UP_ZERO: smp = 8'h00;
                UP_ONES: smp = 8'hFF;
                default: smp = 8'($urandom_range(255));
            endcase
            if (i / 8 < stream_bytes.size())
                smp[0] = stream_bytes[i / 8][7 - i % 8];
            else
                smp[0] = 1'($urandom_range(1));
            drive_sample(smp, (i == 0) && first_start);
        end
        stream_cnt++;
    endtask

    // magic register write once the block has drained
    task automatic write_magic(input logic [31:0] val);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        p_magic = val;
    endtask

    // mostly well-formed files with random content, some broken or noise
    task automatic random_stream();
        int          r;
        int          nbits;
        longint      full;
        int          nbody;
        logic [31:0] mg;
        logic [31:0] sz;
        logic [15:0] nl;
        r  = $urandom_range(99);
        mg = p_magic;
        if (r < 8)
            mg = $urandom;
        else if (r < 14)
            mg = p_magic ^ (32'd1 << $urandom_range(31));
        r = $urandom_range(99);
        if (r < 10)
            sz = 0;
        else if (r < 90)
            sz = $urandom_range(12, 1);
        else if (r < 95)
            sz = $urandom_range(40, 13);
        else
            sz = $urandom;
        r = $urandom_range(99);
        if (r < 25)
            nl = 0;
        else if (r < 92)
            nl = 16'($urandom_range(6, 1));
        else
            nl = 16'($urandom_range(300, 7));
        full = longint'(nl) + longint'(sz);
        if (full > 48)
            nbody = $urandom_range(48);
        else if ($urandom_range(9) == 0)
            nbody = $urandom_range(int'(full));
        else
            nbody = int'(full);
        build_stream(mg, sz, nl, nbody, 1'b0);
        nbits = stream_bytes.size() * 8;
        r = $urandom_range(99);
        if (r < 10) begin
            stream_bytes.delete();
            send_stream($urandom_range(60, 1), UP_RAND, 1'($urandom_range(1)));
        end else if (r < 20) begin
            send_stream($urandom_range(nbits, 1), UP_RAND, 1'b1);
        end else begin
            send_stream(nbits + $urandom_range(12), UP_RAND, 1'b1);
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin : out_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < out_idle_pct);
            end
        end
    end

    // result check and watchdog
    always @(posedge i_clk) begin : check_results
        t_result exp_r;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                kind_cnt[o_kind]++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: kind %0d data %02h", o_kind, o_data_byte);
                    mismatches++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_kind !== exp_r.kind) begin
                        $error("kind: expected %0d, got %0d", exp_r.kind, o_kind);
                        mismatches++;
                    end
                    if (o_data_byte !== exp_r.data_byte) begin
                        $error("data_byte: expected %02h, got %02h",
                               exp_r.data_byte, o_data_byte);
                        mismatches++;
                    end
                    if (o_last !== exp_r.last) begin
                        $error("last: expected %0b, got %0b", exp_r.last, o_last);
                        mismatches++;
                    end
                    if (o_payload_size !== exp_r.payload_size) begin
                        $error("payload_size: expected %08h, got %08h",
                               exp_r.payload_size, o_payload_size);
                        mismatches++;
                    end
                    if (o_name_length !== exp_r.name_length) begin
                        $error("name_length: expected %04h, got %04h",
                               exp_r.name_length, o_name_length);
                        mismatches++;
                    end
                end
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("lsb_stego_extractor: mismatch");
            $finish;
        end
    end

    // stimulus
    initial begin : stimulus
        int goal;
        int dir_sent;
        p_magic = MAGIC_RESET;
        clear_parse();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed streams
        foreach (dir_rows[r]) begin
            if (dir_rows[r].cfg_wr)
                write_magic(dir_rows[r].cfg_val);
            build_stream(dir_rows[r].magic, dir_rows[r].size, dir_rows[r].nlen,
                         dir_rows[r].nbody, dir_rows[r].alt);
            typed_pending = dir_rows[r].typed;
            typed_res     = '{kind: dir_rows[r].exp_kind, data_byte: 8'h00, last: 1'b0,
                              payload_size: dir_rows[r].exp_size,
                              name_length: dir_rows[r].exp_nlen};
            send_stream((dir_rows[r].nbits == 0) ? stream_bytes.size() * 8
                                                 : dir_rows[r].nbits,
                        dir_rows[r].upper, 1'b1);
        end

        // random streams in three idling regimes, sharing the remaining samples
        dir_sent = samples_sent;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    write_magic($urandom);
                    in_idle_pct  = 7;
                    out_idle_pct = 71;
                end
                1: begin
                    write_magic(MAGIC_RESET);
                    in_idle_pct  = 71;
                    out_idle_pct = 7;
                end
                default: begin
                    write_magic($urandom);
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                    hold_pending = 1'b1;
                end
            endcase
            goal = samples_sent + (ITEM_GOAL - dir_sent) / 3;
            while (samples_sent < goal)
                random_stream();
        end

        // drain
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("run: %0d streams, %0d samples (%0d parsed), %0d results checked",
                 stream_cnt, samples_sent, parsed_cnt, results_seen);
        $display("run: %0d headers, %0d name, %0d payload, %0d magic errors",
                 kind_cnt[K_HEADER], kind_cnt[K_NAME], kind_cnt[K_PAYLOAD],
                 kind_cnt[K_ERROR]);
        if (mismatches == 0)
            $display("lsb_stego_extractor: match");
        else
            $display("lsb_stego_extractor: mismatch");
        $finish;
    end

endmodule
